FILE: src/top_k_nearest_merge_heap_defines.svh
// Assertion macros for the top-k merge heap block
`ifndef TOP_K_NEAREST_MERGE_HEAP_DEFINES_SVH
`define TOP_K_NEAREST_MERGE_HEAP_DEFINES_SVH
// Implication checked every clock edge outside reset
`define TKH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define TKH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/tkh_pkg.sv
// Package: types, codes and helpers for the top-k merge heap
`timescale 1ns / 1ps
package tkh_pkg;
  localparam int HEAP_CAPACITY = 32;
  localparam int AW = $clog2(HEAP_CAPACITY);
  localparam int SW = $clog2(HEAP_CAPACITY + 1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_TOTAL = 2'd1;
  localparam logic [1:0] OP_ERROR = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  localparam logic [1:0] ERR_OOM = 2'd1;
  localparam logic [1:0] ERR_PRECOND = 2'd2;

  localparam logic [1:0] KIND_CANCEL = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_PRECOND = 2'd1;
  localparam logic [1:0] ST_OOM = 2'd2;

  localparam logic [1:0] CFG_K = 2'd0;
  localparam logic [1:0] CFG_NV = 2'd1;
  localparam logic [1:0] CFG_CONS = 2'd2;
  localparam logic [1:0] CFG_PART = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] distance;
    logic [31:0] key_rank;
    logic [31:0] count;
    logic [1:0]  err_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [1:0]  status;
    logic [31:0] entry_distance;
    logic [31:0] entry_key;
    logic [31:0] total;
    logic        overflow;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] cdist;
    logic [31:0] key;
  } cand_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP,
    S_FIN_RD, S_FIN_EMIT, S_FIN_MOVE, S_STATUS, S_OUT_WAIT
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic latch_in;
    logic push;        // write candidate at index size, size++
    logic replace;     // write candidate at root
    logic up_rd;       // read parent of current index
    logic up_swap;     // apply sift-up step
    logic dn_rd;       // read children of current index
    logic dn_swap;     // apply sift-down step
    logic rd_root;     // read root and last entry
    logic pop_move;    // move last to root, size--
    logic total_add;
    logic err_apply;
    logic clear;
    logic emit_cancel;
    logic emit_entry;
    logic emit_status;
  } tkh_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [1:0] op;
    logic       do_push;
    logic       do_replace;
    logic       cancel;
    logic       up_more;
    logic       dn_more;
    logic       heap_empty;
    logic       fail;
  } tkh_sts_t;

  function automatic logic ranks_above(cand_t a, cand_t b);
    if (a.cdist != b.cdist) return a.cdist > b.cdist;
    return a.key < b.key;
  endfunction
endpackage

FILE: src/tkh_ctrl.sv
// Controller: sequences heap insert, replace and drain steps, totals, error reports and status
`timescale 1ns / 1ps
`include "top_k_nearest_merge_heap_defines.svh"
module tkh_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_busy,
  input  tkh_pkg::tkh_sts_t sts,
  output tkh_pkg::tkh_cmd_t cmd
);
  import tkh_pkg::*;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts.op)
          OP_ADD: begin
            if (sts.do_push) begin
              cmd.push = 1'b1;
              state_nxt = S_UP_RD;
            end else if (sts.do_replace) begin
              cmd.replace = 1'b1;
              state_nxt = S_DN_RD;
            end else state_nxt = S_IDLE;
          end
          OP_TOTAL: begin
            cmd.total_add = 1'b1;
            state_nxt = S_IDLE;
          end
          OP_ERROR: begin
            cmd.err_apply = 1'b1;
            if (sts.cancel) begin
              if (!out_busy) begin
                cmd.emit_cancel = 1'b1;
                state_nxt = S_IDLE;
              end else begin
                cmd.err_apply = 1'b0;
              end
            end else state_nxt = S_IDLE;
          end
          OP_FINISH: begin
            if (sts.fail || sts.heap_empty) state_nxt = S_STATUS;
            else begin
              cmd.rd_root = 1'b1;
              state_nxt = S_FIN_EMIT;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_UP_RD: begin
        if (sts.up_more) begin
          cmd.up_rd = 1'b1;
          state_nxt = S_UP_CMP;
        end else state_nxt = S_IDLE;
      end
      S_UP_CMP: begin
        cmd.up_swap = 1'b1;
        state_nxt = S_UP_RD;
      end
      S_DN_RD: begin
        if (sts.dn_more) begin
          cmd.dn_rd = 1'b1;
          state_nxt = S_DN_CMP;
        end else state_nxt = S_IDLE;
      end
      S_DN_CMP: begin
        cmd.dn_swap = 1'b1;
        state_nxt = S_DN_RD;
      end
      S_FIN_RD: begin
        if (sts.heap_empty) state_nxt = S_STATUS;
        else begin
          cmd.rd_root = 1'b1;
          state_nxt = S_FIN_EMIT;
        end
      end
      S_FIN_EMIT: begin
        if (!out_busy) begin
          cmd.emit_entry = 1'b1;
          state_nxt = S_FIN_MOVE;
        end
      end
      S_FIN_MOVE: begin
        cmd.pop_move = 1'b1;
        state_nxt = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        // drain sift then next root
        if (sts.dn_more) begin
          cmd.dn_rd = 1'b1;
          state_nxt = S_DN_CMP;
        end else state_nxt = S_FIN_RD;
      end
      S_STATUS: begin
        if (!out_busy) begin
          cmd.emit_status = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // sift-down during drain returns to the drain loop
    if (state_r == S_DN_CMP && sts.op == OP_FINISH) state_nxt = S_OUT_WAIT;
    if (state_r == S_DN_RD && sts.op == OP_FINISH && !sts.dn_more) state_nxt = S_FIN_RD;
  end

  `TKH_ASSERT_IMP(a_stall_busy, clk, rst_n, state_r != S_IDLE, in_stall)
  `TKH_ASSERT_IMP(a_one_emit, clk, rst_n, 1'b1,
    $countones({cmd.emit_cancel, cmd.emit_entry, cmd.emit_status}) <= 1)
  `TKH_ASSERT_IMP(a_emit_free, clk, rst_n,
    cmd.emit_cancel || cmd.emit_entry || cmd.emit_status, !out_busy)
  `TKH_ASSERT_NXT(a_accept_decide, clk, rst_n, cmd.latch_in, state_r == S_DECIDE)
endmodule

FILE: src/tkh_dp.sv
// Datapath: heap memory, counters, flags and the output register
`timescale 1ns / 1ps
module tkh_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  tkh_pkg::in_item_t in_data,
  input  logic [5:0]        k_limit,
  input  logic              non_vector_mode,
  input  logic              consistency_enabled,
  input  logic              partial_allowed,
  input  tkh_pkg::tkh_cmd_t cmd,
  output tkh_pkg::tkh_sts_t sts,
  output logic              out_busy,
  output logic              out_valid,
  input  logic              out_stall,
  output tkh_pkg::out_item_t out_data
);
  import tkh_pkg::*;

  cand_t mem_a [HEAP_CAPACITY];  // one write port, reads registered
  in_item_t item_r;
  logic [SW-1:0] size_r;
  logic [AW-1:0] idx_r;
  logic [31:0] total_r;
  logic cbad_r, oom_r, drop_r;
  cand_t cur_r, root_r;
  logic lc_ok_r, rc_ok_r;
  logic ov_r;
  out_item_t od_r;

  logic [SW-1:0] keff;
  logic [SW:0] lidx_w, ridx_w;
  logic [AW-1:0] pidx;
  logic [32:0] sum;
  logic cons_nxt;
  logic mw_en;
  logic [AW-1:0] mw_a;
  cand_t mw_d;
  logic [AW-1:0] ra, rb;
  cand_t rda, rdb;
  logic pick_l, pick_r;

  assign keff = (k_limit > 6'(HEAP_CAPACITY)) ? SW'(HEAP_CAPACITY) : SW'(k_limit);
  assign lidx_w = (SW+1)'({idx_r, 1'b1});
  assign ridx_w = lidx_w + (SW+1)'(1);
  assign pidx = AW'((idx_r - AW'(1)) >> 1);
  assign sum = {1'b0, total_r} + {1'b0, item_r.count};
  assign cons_nxt = cbad_r | (consistency_enabled & (item_r.err_code == ERR_PRECOND));

  // reads: two ports, address chosen by the command
  always_comb begin
    ra = '0;
    rb = '0;
    if (cmd.up_rd) ra = pidx;
    if (cmd.dn_rd) begin
      ra = lidx_w[AW-1:0];
      rb = ridx_w[AW-1:0];
    end
    if (cmd.rd_root) begin
      ra = '0;
      rb = AW'(size_r - SW'(1));
    end
  end
  // hold the read data until the next read command
  always_ff @(posedge clk) begin
    if (cmd.up_rd || cmd.dn_rd || cmd.rd_root) begin
      rda <= mem_a[ra];
      rdb <= mem_a[rb];
    end
  end

  assign pick_l = lc_ok_r && ranks_above(rda, cur_r) &&
                  !(rc_ok_r && ranks_above(rdb, rda));
  assign pick_r = rc_ok_r && ranks_above(rdb, cur_r) &&
                  !(lc_ok_r && !ranks_above(rdb, rda));

  // single write per cycle: a swap writes cur at the neighbor's index, cur stays in a register
  always_comb begin
    mw_en = 1'b0;
    mw_a = '0;
    mw_d = cur_r;
    if (cmd.push) begin
      mw_en = 1'b1;
      mw_a = AW'(size_r);
      mw_d = {item_r.distance, item_r.key_rank};
    end else if (cmd.replace) begin
      mw_en = 1'b1;
      mw_a = '0;
      mw_d = {item_r.distance, item_r.key_rank};
    end else if (cmd.up_swap) begin
      mw_en = 1'b1;
      mw_a = ranks_above(cur_r, rda) ? pidx : idx_r;
      mw_d = cur_r;
    end else if (cmd.dn_swap) begin
      mw_en = 1'b1;
      mw_a = pick_l ? lidx_w[AW-1:0] : (pick_r ? ridx_w[AW-1:0] : idx_r);
      mw_d = cur_r;
    end else if (cmd.pop_move) begin
      mw_en = 1'b1;
      mw_a = '0;
      mw_d = rdb;
    end
  end

  // sift step: cur to parent or child, which moves to cur's index later (written here too)
  cand_t up_hold_r;
  logic up_fix_r;
  logic [AW-1:0] up_fix_a_r;
  always_ff @(posedge clk) begin
    if (mw_en) mem_a[mw_a] <= mw_d;
    else if (up_fix_r) mem_a[up_fix_a_r] <= up_hold_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_fix_r <= 1'b0;
    end else begin
      up_fix_r <= 1'b0;
      if (cmd.up_swap && ranks_above(cur_r, rda)) begin
        up_fix_r <= 1'b1;
        up_fix_a_r <= idx_r;
        up_hold_r <= rda;
      end
      if (cmd.dn_swap && (pick_l || pick_r)) begin
        up_fix_r <= 1'b1;
        up_fix_a_r <= idx_r;
        up_hold_r <= pick_l ? rda : rdb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
      total_r <= '0;
      cbad_r <= 1'b0;
      oom_r <= 1'b0;
      drop_r <= 1'b0;
      ov_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (cmd.latch_in) item_r <= in_data;
      if (cmd.latch_in && in_data.op == OP_ADD && non_vector_mode &&
          size_r >= SW'(HEAP_CAPACITY)) drop_r <= 1'b1;
      if (cmd.push) begin
        size_r <= size_r + SW'(1);
        idx_r <= AW'(size_r);
        cur_r <= {item_r.distance, item_r.key_rank};
      end
      if (cmd.replace) begin
        idx_r <= '0;
        cur_r <= {item_r.distance, item_r.key_rank};
      end
      if (cmd.up_swap) begin
        if (ranks_above(cur_r, rda)) idx_r <= pidx;
        else idx_r <= '0;
      end
      if (cmd.dn_rd) begin
        lc_ok_r <= lidx_w < (SW+1)'(size_r);
        rc_ok_r <= ridx_w < (SW+1)'(size_r);
      end
      if (cmd.dn_swap) begin
        if (pick_l) idx_r <= lidx_w[AW-1:0];
        else if (pick_r) idx_r <= ridx_w[AW-1:0];
        else begin
          lc_ok_r <= 1'b0;
          rc_ok_r <= 1'b0;
          idx_r <= '1;
        end
      end
      if (cmd.pop_move) begin
        size_r <= size_r - SW'(1);
        idx_r <= '0;
        cur_r <= rdb;
      end
      if (cmd.total_add) total_r <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (cmd.err_apply) begin
        cbad_r <= cons_nxt;
        if (item_r.err_code == ERR_OOM) oom_r <= 1'b1;
      end
      if (cmd.clear) begin
        size_r <= '0;
        total_r <= '0;
        cbad_r <= 1'b0;
        oom_r <= 1'b0;
        drop_r <= 1'b0;
      end
      if (out_valid && !out_stall) ov_r <= 1'b0;
      if (cmd.emit_cancel || cmd.emit_entry || cmd.emit_status) ov_r <= 1'b1;
    end
  end

  // sift loops stop when the heap order holds or the index runs off the tree
  logic dn_live_r;
  always_ff @(posedge clk) begin
    if (!rst_n) dn_live_r <= 1'b0;
    else if (cmd.replace || cmd.pop_move) dn_live_r <= 1'b1;
    else if (cmd.dn_swap && !(pick_l || pick_r)) dn_live_r <= 1'b0;
    else if (cmd.dn_rd && !(lidx_w < (SW+1)'(size_r))) dn_live_r <= 1'b0;
  end
  logic up_live_r;
  always_ff @(posedge clk) begin
    if (!rst_n) up_live_r <= 1'b0;
    else if (cmd.push) up_live_r <= 1'b1;
    else if (cmd.up_swap && !ranks_above(cur_r, rda)) up_live_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_cancel) od_r <= '{KIND_CANCEL, ST_OK, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0};
    else if (cmd.emit_entry)
      od_r <= '{KIND_ENTRY, ST_OK, rda.cdist, rda.key, total_r, drop_r, 1'b0};
    else if (cmd.emit_status) begin
      if (cbad_r) od_r <= '{KIND_STATUS, ST_PRECOND, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1};
      else if (oom_r) od_r <= '{KIND_STATUS, ST_OOM, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1};
      else od_r <= '{KIND_STATUS, ST_OK, 32'd0, 32'd0, total_r, drop_r, 1'b1};
    end
  end

  assign out_valid = ov_r;
  assign out_data = od_r;
  assign out_busy = ov_r && out_stall;

  always_comb begin
    sts.op = item_r.op;
    sts.do_push = non_vector_mode ? (size_r < SW'(HEAP_CAPACITY)) : (size_r < keff);
    sts.do_replace = !non_vector_mode && (size_r != '0) &&
                     (item_r.distance < root_r.cdist);
    sts.cancel = (item_r.err_code == ERR_OOM) || !partial_allowed || cons_nxt;
    sts.up_more = up_live_r && (idx_r != '0);
    sts.dn_more = dn_live_r && (lidx_w < (SW+1)'(size_r));
    sts.heap_empty = (size_r == '0);
    sts.fail = cbad_r || oom_r;
  end

  // root shadow kept for the replace compare
  always_ff @(posedge clk) begin
    if (mw_en && mw_a == '0) root_r <= mw_d;
    else if (up_fix_r && up_fix_a_r == '0) root_r <= up_hold_r;
  end
endmodule

FILE: src/top_k_nearest_merge_heap.sv
// Top level: top-k nearest-neighbor merge heap with its config registers
//
// Usage:
//  in_* channel: one beat per op (add neighbor, add total, error report, finish).
//  out_* channel: cancel requests, result entries furthest first, then a final status
//  beat with last set. cfg_* writes k_limit, non_vector_mode, consistency_enabled and
//  partial_allowed; the user must do so only while the block is idle (unenforced).
// Sequencing:
//  One item at a time. An add sifts one heap level per read/compare pair of states,
//  using the two-port heap memory with a registered read. A finish emits one entry
//  per pop, each pop sifting the new root before the next entry.
// Reset: synchronous, rst_n low clears heap size, totals, flags and config to
//  their defaults (k_limit 10, partial_allowed 1). The heap memory is not cleared.
// Stall: out_stall holds the output register; the controller waits before the next
//  emit, and in_stall stays high until the current item finishes.
`timescale 1ns / 1ps
module top_k_nearest_merge_heap (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tkh_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tkh_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_wdata
);
  import tkh_pkg::*;

  logic [5:0] k_r;
  logic nv_r, cons_r, part_r;
  tkh_cmd_t cmd;
  tkh_sts_t sts;
  logic out_busy;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 6'd10;
      nv_r <= 1'b0;
      cons_r <= 1'b0;
      part_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_K: k_r <= cfg_wdata;
        CFG_NV: nv_r <= cfg_wdata[0];
        CFG_CONS: cons_r <= cfg_wdata[0];
        CFG_PART: part_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  tkh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_busy(out_busy), .sts(sts), .cmd(cmd)
  );

  tkh_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .k_limit(k_r),
    .non_vector_mode(nv_r), .consistency_enabled(cons_r), .partial_allowed(part_r),
    .cmd(cmd), .sts(sts), .out_busy(out_busy), .out_valid(out_valid),
    .out_stall(out_stall), .out_data(out_data)
  );
endmodule
